// ===== rtl/ssmu_pkg.sv =====
package ssmu_pkg;

    localparam int CAPACITY = 7;
    localparam int SYM_W    = 5;
    localparam int CNT_W    = 3;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    // operation broadcast to every cell
    typedef struct packed {
        logic             ins_en;
        logic             rem_en;
        logic [SYM_W-1:0] symbol;
    } t_cell_ctl;

    // data handed from a cell to its right neighbor
    typedef struct packed {
        logic             le;
        logic             seen;
        logic [CNT_W-1:0] cnt;
        logic [SYM_W-1:0] entry;
    } t_link;

endpackage

// ===== rtl/ssmu_cell.sv =====
module ssmu_cell (
    input  logic                    i_clk,
    input  ssmu_pkg::t_cell_ctl     i_ctl,
    input  logic                    i_occupied,
    input  ssmu_pkg::t_link         i_from_left,
    input  logic [ssmu_pkg::SYM_W-1:0] i_right_entry,
    output ssmu_pkg::t_link         o_to_right
);
    import ssmu_pkg::*;

    logic [SYM_W-1:0] r_entry;
    logic [SYM_W-1:0] n_entry;
    logic             match;
    logic             le;

    assign match = i_occupied && (r_entry == i_ctl.symbol);
    assign le    = i_occupied && (r_entry <= i_ctl.symbol);

    assign o_to_right.le    = le;
    assign o_to_right.seen  = i_from_left.seen | match;
    assign o_to_right.cnt   = i_from_left.cnt + CNT_W'(match);
    assign o_to_right.entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins_en) begin
            // shift up past the insert point, drop the new code at it
            if (!i_from_left.le) begin
                n_entry = i_from_left.entry;
            end else if (!le) begin
                n_entry = i_ctl.symbol;
            end
        end else if (i_ctl.rem_en && o_to_right.seen) begin
            // close the gap from the first match upward
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ===== rtl/sorted_small_multiset_unit.sv =====
// the result is registered and valid in the cycle after the request is accepted
// throughput: one request per cycle while the input is not stalled; all cells compare and shift in the same cycle
// input is stalled only while a result is held and the output side stalls
// reset clears the fill count and the output valid; stored codes are not cleared
module sorted_small_multiset_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_mode,
    input  logic [ssmu_pkg::SYM_W-1:0]  i_symbol,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_success,
    output logic [ssmu_pkg::CNT_W-1:0]  o_match_count,
    output logic [ssmu_pkg::CNT_W-1:0]  o_occupancy
);
    import ssmu_pkg::*;

    // control state
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] n_fill;
    logic             r_out_valid;
    // result payload
    logic             r_success;
    logic [CNT_W-1:0] r_match_count;
    logic [CNT_W-1:0] r_occupancy;

    logic             accept;
    t_mode            mode;
    logic             ins_ok;
    logic             rem_ok;
    logic             ok;
    logic [CNT_W-1:0] n_count;
    t_cell_ctl        ctl;

    // link i enters cell i from the left; link CAPACITY leaves the last cell
    t_link            link [CAPACITY+1];

    assign mode       = t_mode'(i_mode);
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    // chain head: everything to the left counts as below the code
    assign link[0].le    = 1'b1;
    assign link[0].seen  = 1'b0;
    assign link[0].cnt   = '0;
    assign link[0].entry = '0;

    // matches and first-match flag come out of the tail of the chain
    always_comb begin
        ins_ok = 1'b0;
        rem_ok = 1'b0;
        ok     = 1'b0;
        case (mode)
            MODE_INSERT: begin
                ins_ok = (r_fill < FULL_COUNT);
                ok     = ins_ok;
            end
            MODE_REMOVE: begin
                rem_ok = link[CAPACITY].seen;
                ok     = rem_ok;
            end
            MODE_QUERY: begin
                ok = 1'b1;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    assign ctl.ins_en = accept && ins_ok;
    assign ctl.rem_en = accept && rem_ok;
    assign ctl.symbol = i_symbol;

    // count and occupancy after the operation
    assign n_count = link[CAPACITY].cnt + CNT_W'(ins_ok) - CNT_W'(rem_ok);
    assign n_fill  = r_fill + CNT_W'(ctl.ins_en) - CNT_W'(ctl.rem_en);

    // row of cells, each holding one stored code
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [SYM_W-1:0] right_entry;
        logic             occupied;

        if (i == CAPACITY - 1) begin : g_tail
            assign right_entry = link[i+1].entry;
        end else begin : g_body
            assign right_entry = link[i+2].entry;
        end

        assign occupied = (r_fill > CNT_W'(i));

        ssmu_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (ctl),
            .i_occupied    (occupied),
            .i_from_left   (link[i]),
            .i_right_entry (right_entry),
            .o_to_right    (link[i+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill <= n_fill;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register, loaded with each accepted request
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_success     <= ok;
            r_match_count <= n_count;
            r_occupancy   <= n_fill;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_success     = r_success;
    assign o_match_count = r_match_count;
    assign o_occupancy   = r_occupancy;

endmodule
